[hdl/bdal_pkg.sv]
// ----------------------------------------------------------------------------
// bdal_pkg - shared types and constants
// Character codes, operation codes and the entry carried from the
// converter to the character sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bdal_pkg;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_WIDE = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [19:0] bcd;
	} entry_t;

endpackage

`default_nettype wire

[hdl/bdal_front.sv]
// ----------------------------------------------------------------------------
// bdal_front - input stage and binary to BCD converter
// Takes one number, runs double dabble four bits per cycle and hands the
// packed BCD digits to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bdal_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic            operation,
	input  wire logic [15:0]     number,
	output logic                 q_push,
	input  wire logic            q_full,
	output bdal_pkg::entry_t     q_data
);
	import bdal_pkg::*;

	logic        busy_q;
	logic [2:0]  left_q;
	op_t         op_q;
	logic [15:0] bin_q;
	logic [19:0] bcd_q;
	logic [15:0] bin_nxt;
	logic [19:0] bcd_nxt;
	logic        accept;

	always_comb begin
		logic [35:0] w;
		w = {bcd_q, bin_q};
		for (int k = 0; k < 4; k++) begin
			for (int d = 0; d < 5; d++) begin
				if (w[16 + 4*d +: 4] >= 4'd5) begin
					w[16 + 4*d +: 4] = w[16 + 4*d +: 4] + 4'd3;
				end
			end
			w = {w[34:0], 1'b0};
		end
		bcd_nxt = w[35:16];
		bin_nxt = w[15:0];
	end

	assign full   = busy_q;
	assign accept = push && !busy_q;
	assign q_push = busy_q && (left_q == 3'd0);
	assign q_data = '{op: op_q, bcd: bcd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= 3'd0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				left_q <= (op_t'(operation) == OP_BYTE) ? 3'd2 : 3'd4;
			end else if (busy_q && left_q != 3'd0) begin
				left_q <= left_q - 3'd1;
			end else if (q_push && !q_full) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(operation);
			bcd_q <= '0;
			bin_q <= (op_t'(operation) == OP_BYTE) ? {number[7:0], 8'h00} : number;
		end else if (busy_q && left_q != 3'd0) begin
			bcd_q <= bcd_nxt;
			bin_q <= bin_nxt;
		end
	end

endmodule

`default_nettype wire

[hdl/bdal_fifo.sv]
// ----------------------------------------------------------------------------
// bdal_fifo - short entry queue
// Decouples the converter from the character sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdal_fifo #(
	parameter int DEPTH = bdal_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	output logic                   full,
	input  wire bdal_pkg::entry_t  wr_data,
	input  wire logic              rd_en,
	output logic                   empty,
	output bdal_pkg::entry_t       rd_data
);
	import bdal_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bdal_back.sv]
// ----------------------------------------------------------------------------
// bdal_back - character sequencer
// Walks one entry's digits, then CR and LF, one character per cycle into
// an output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdal_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire bdal_pkg::entry_t  q_data,
	output logic                   out_valid,
	input  wire logic              out_pop,
	output logic [7:0]             out_char,
	output logic                   out_last
);
	import bdal_pkg::*;

	logic        act_q;
	entry_t      cur_q;
	logic [2:0]  pos_q;
	logic        oval_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        oready;
	logic        emit;
	logic [2:0]  ndig;
	logic [2:0]  idx;
	logic [7:0]  ch;
	logic        is_lf;

	always_comb begin
		ndig  = (cur_q.op == OP_BYTE) ? 3'd3 : 3'd5;
		idx   = ndig - 3'd1 - pos_q;
		is_lf = (pos_q == ndig + 3'd1);
		if (pos_q < ndig) begin
			ch = CHAR_ZERO | {4'h0, cur_q.bcd[{idx, 2'b00} +: 4]};
		end else if (pos_q == ndig) begin
			ch = CHAR_CR;
		end else begin
			ch = CHAR_LF;
		end
	end

	assign oready    = !oval_q || out_pop;
	assign emit      = act_q && oready;
	assign q_pop     = !q_empty && (!act_q || (emit && is_lf));
	assign out_valid = oval_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			pos_q  <= 3'd0;
			oval_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q <= 1'b1;
				pos_q <= 3'd0;
			end else if (emit) begin
				if (is_lf) begin
					act_q <= 1'b0;
				end
				pos_q <= pos_q + 3'd1;
			end
			if (emit) begin
				oval_q <= 1'b1;
			end else if (out_pop) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			char_q <= ch;
			last_q <= is_lf;
		end
	end

endmodule

`default_nettype wire

[hdl/binary_to_decimal_ascii_line.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_line - number to decimal ASCII line
// Prints a 16-bit number as five digits or its low byte as three digits,
// followed by CR and LF; LF carries last.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------
//   input    | push / full         | operation, number
//   result   | empty / pop         | character, last
//
// One character leaves per cycle while pop is held: seven characters per
// 16-bit item, five per byte. The converter runs four double dabble shifts
// per cycle and outpaces the result channel, so the result beat rate sets throughput.
// Reset clears the queue and sequencer; no clearing pass is needed.
// A stalled result holds its beat; the queue lets the converter run ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_line #(
	parameter int QDEPTH = bdal_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        operation,
	input  wire logic [15:0] number,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       character,
	output logic             last
);
	import bdal_pkg::*;

	logic   wq_push;
	logic   wq_full;
	entry_t wq_data;
	logic   rq_pop;
	logic   rq_empty;
	entry_t rq_data;
	logic   out_valid;

	bdal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.number    (number),
		.q_push    (wq_push),
		.q_full    (wq_full),
		.q_data    (wq_data)
	);

	bdal_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wq_push),
		.full    (wq_full),
		.wr_data (wq_data),
		.rd_en   (rq_pop),
		.empty   (rq_empty),
		.rd_data (rq_data)
	);

	bdal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (rq_empty),
		.q_pop     (rq_pop),
		.q_data    (rq_data),
		.out_valid (out_valid),
		.out_pop   (pop),
		.out_char  (character),
		.out_last  (last)
	);

	assign empty = !out_valid;

endmodule

`default_nettype wire

[hdl/bdal_checker.sv]
// ----------------------------------------------------------------------------
// bdal_checker - port-level checks
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bdal_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] character,
	input wire logic       last
);
	import bdal_pkg::*;

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(character) && $stable(last)))
		else $error("stalled result beat changed");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (character == CHAR_LF))
		else $error("last on a character other than LF");

	a_lf_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && character == CHAR_LF) |-> last)
		else $error("LF without last");

	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && character == CHAR_CR) |=> (!empty && last))
		else $error("CR not followed at once by LF");

endmodule

bind binary_to_decimal_ascii_line bdal_checker u_bdal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.character (character),
	.last      (last)
);

`default_nettype wire
